// File: rtl/mmsh_pkg.sv
// Shared types, constants and helpers for the multi-mode string hash engine.
`timescale 1ns / 1ps
`default_nettype none

package mmsh_pkg;

	typedef enum logic [2:0] {
		MODE_RS   = 3'd0,
		MODE_JS   = 3'd1,
		MODE_ELF  = 3'd2,
		MODE_BKDR = 3'd3,
		MODE_DJB  = 3'd4,
		MODE_FNV  = 3'd5
	} hash_mode_t;

	// Register word index (paddr[2])
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SEED = 1'b1;

	localparam logic [2:0]  MODE_RESET   = 3'd3;
	localparam logic [31:0] SEED_RESET   = 32'd131;

	localparam logic [31:0] RS_STEP_MUL  = 32'd378551;
	localparam logic [31:0] RS_INIT_MUL  = 32'd63689;
	localparam logic [31:0] JS_INIT      = 32'd1315423911;
	localparam logic [31:0] ELF_TOP_MASK = 32'hF000_0000;
	localparam logic [31:0] DJB_INIT     = 32'd5381;
	localparam logic [31:0] FNV_OFFSET   = 32'h811C_9DC5;
	localparam logic [31:0] FNV32_MULT   = 32'h0100_0193;

	typedef struct packed {
		logic [2:0]  hash_mode;
		logic [31:0] bkdr_seed;
		logic        reload;       // mode write at this edge
		logic [2:0]  reload_mode;  // mode being written
	} cfg_t;

	function automatic logic [31:0] init_hash(input logic [2:0] mode);
		logic [31:0] v;
		unique case (mode)
			MODE_JS:  v = JS_INIT;
			MODE_DJB: v = DJB_INIT;
			MODE_FNV: v = FNV_OFFSET;
			default:  v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mmsh_regs.sv
// APB register file: hash mode and BKDR seed.
`timescale 1ns / 1ps
`default_nettype none

module mmsh_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output mmsh_pkg::cfg_t         cfg
);
	import mmsh_pkg::*;

	logic [2:0]  hash_mode_q;
	logic [31:0] bkdr_seed_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q <= MODE_RESET;
			bkdr_seed_q <= SEED_RESET;
		end else begin
			if (wr_en) begin
				unique case (paddr[2])
					REG_MODE: hash_mode_q <= pwdata[2:0];
					REG_SEED: bkdr_seed_q <= pwdata;
					default:  ;
				endcase
			end
		end
	end

	// reload fires on the write edge itself and carries the incoming mode
	assign cfg.hash_mode   = hash_mode_q;
	assign cfg.bkdr_seed   = bkdr_seed_q;
	assign cfg.reload      = wr_en && (paddr[2] == REG_MODE);
	assign cfg.reload_mode = pwdata[2:0];

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {29'd0, hash_mode_q};
			default:  prdata = bkdr_seed_q;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/mmsh_core.sv
// Hash state registers and the per-byte mixing logic for all six modes.
`timescale 1ns / 1ps
`default_nettype none

module mmsh_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mmsh_pkg::cfg_t    cfg,
	input  wire logic              step,
	input  wire logic [7:0]        data_s1,
	input  wire logic              last_s1,
	output logic [31:0]            hash_next
);
	import mmsh_pkg::*;

	logic [31:0] running_hash_q;
	logic [31:0] rs_mult_q;
	logic [31:0] c;
	logic [31:0] h;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic [31:0] rs_next;
	logic [31:0] elf_t;
	logic [31:0] elf_x;

	assign c = {{24{data_s1[7]}}, data_s1};
	assign h = running_hash_q;

	// one shared multiplier for RS, BKDR and FNV
	always_comb begin
		mul_a = h;
		mul_b = cfg.bkdr_seed;
		unique case (cfg.hash_mode)
			MODE_RS:  mul_b = rs_mult_q;
			MODE_FNV: begin
				mul_a = h ^ c;
				mul_b = FNV32_MULT;
			end
			default:  ;
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign rs_next = rs_mult_q * RS_STEP_MUL;

	assign elf_t = {h[27:0], 4'd0} + c;
	assign elf_x = elf_t & ELF_TOP_MASK;

	always_comb begin
		unique case (cfg.hash_mode)
			MODE_JS:  hash_next = h ^ ({h[26:0], 5'd0} + c + {2'd0, h[31:2]});
			MODE_ELF: hash_next = (elf_t ^ {24'd0, elf_x[31:24]}) & ~elf_x;
			MODE_DJB: hash_next = h + {h[26:0], 5'd0} + c;
			MODE_FNV: hash_next = prod;
			default:  hash_next = prod + c;   // RS, BKDR and unused codes
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= init_hash(MODE_RESET);
			rs_mult_q      <= RS_INIT_MUL;
		end else if (cfg.reload) begin
			running_hash_q <= init_hash(cfg.reload_mode);
			rs_mult_q      <= RS_INIT_MUL;
		end else if (step && last_s1) begin
			running_hash_q <= init_hash(cfg.hash_mode);
			rs_mult_q      <= RS_INIT_MUL;
		end else if (step) begin
			running_hash_q <= hash_next;
			if (cfg.hash_mode == MODE_RS) begin
				rs_mult_q <= rs_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/multi_mode_string_hash.sv
// Top level: byte input stage, hash core, result register and APB port.
//
// Byte-serial 32-bit string hash (RS, JS, ELF, BKDR, DJB, FNV-1a).
// Input channel: data_byte/last_byte with byte_valid, backpressured by
// byte_stall. A byte is taken on an edge with byte_valid high and
// byte_stall low. One byte per cycle is sustained while no final byte waits on a stalled result.
// Output channel: hash_value with hash_valid, backpressured by hash_stall.
// Only a byte with last_byte set produces an item.
// Path of a result: the last byte is registered in the input register,
// then the mix of that byte lands in the result register (it can wait
// in the input register while the result register is stalled).
// The loop through the running hash and the shared 32x32 multiplier sets
// the one-byte-per-cycle rate.
// A stalled result holds; non-final bytes keep flowing, and a final byte
// waits in the input register until the result register frees.
// Reset loads mode BKDR, seed 131 and the BKDR initial hash.
// A mode write over APB restarts the string with the new mode's initial
// values at the write edge; seed writes apply from the next byte.
`timescale 1ns / 1ps
`default_nettype none

module multi_mode_string_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	output logic [31:0]      hash_value,
	output logic             hash_valid,
	input  wire logic        hash_stall
);
	import mmsh_pkg::*;

	cfg_t        cfg;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        advance;
	logic [31:0] hash_next;
	logic [31:0] hash_value_q;
	logic        hash_valid_q;

	mmsh_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mmsh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.data_s1   (data_s1),
		.last_s1   (last_s1),
		.hash_next (hash_next)
	);

	// only a final byte needs a free result slot
	assign advance    = valid_s1 && (!last_s1 || !hash_valid_q || !hash_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			hash_valid_q <= 1'b1;
		end else if (!hash_stall) begin
			hash_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			hash_value_q <= hash_next;
		end
	end

	assign hash_value = hash_value_q;
	assign hash_valid = hash_valid_q;

endmodule

`default_nettype wire
